### design/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// shared types, codes and field layout of the interrupt controller
// ----------------------------------------------------------------------------
package sic_pkg;

    localparam int PRIORITY_SLOTS_DEF = 40;

    // stream widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    // input item layout in s_axis_tdata
    localparam int F_OFF_LSB  = 0;
    localparam int F_OFF_W    = 14;
    localparam int F_SIZE_LSB = 14;
    localparam int F_SIZE_W   = 3;
    localparam int F_WD_LSB   = 17;
    localparam int F_WD_W     = 32;
    localparam int F_CRN_LSB  = 49;
    localparam int F_CRN_W    = 4;
    localparam int F_OP1_LSB  = 53;
    localparam int F_OP1_W    = 3;
    localparam int F_CRM_LSB  = 56;
    localparam int F_CRM_W    = 4;
    localparam int F_OP2_LSB  = 60;
    localparam int F_OP2_W    = 3;
    localparam int F_TWO_BIT  = 63;
    localparam int F_RX_LSB   = 64;
    localparam int F_RX_W     = 4;
    localparam int F_SRC_LSB  = 68;
    localparam int F_SRC_W    = 6;
    localparam int F_RAISE_BIT = 74;

    // action codes carried in tuser
    typedef enum logic [2:0] {
        ACT_BUS_RD = 3'd0,
        ACT_BUS_WR = 3'd1,
        ACT_COP_RD = 3'd2,
        ACT_COP_WR = 3'd3,
        ACT_EVENT  = 3'd4
    } t_action;

    // word register kinds
    typedef enum logic [2:0] {
        KIND_IRQP  = 3'd0,
        KIND_MASK  = 3'd1,
        KIND_LEVEL = 3'd2,
        KIND_FIQP  = 3'd3,
        KIND_PEND  = 3'd4
    } t_kind;

    localparam logic [2:0]  SIZE_WORD     = 3'd4;
    localparam logic [13:0] OFF_W0_LAST   = 14'd4;
    localparam logic [13:0] OFF_CTRL      = 14'd5;
    localparam logic [13:0] OFF_HP        = 14'd6;
    localparam logic [13:0] OFF_SLOTA_LO  = 14'd7;
    localparam logic [13:0] OFF_SLOTA_HI  = 14'd38;
    localparam logic [13:0] OFF_W1_LO     = 14'd39;
    localparam logic [13:0] OFF_W1_HI     = 14'd43;
    localparam logic [13:0] OFF_SLOTB_LO  = 14'd44;
    localparam logic [13:0] OFF_SLOTB_HI  = 14'd51;
    localparam logic [5:0]  SLOTB_BASE    = 6'd12;

    localparam logic [3:0]  CRN_HP        = 4'd5;
    localparam logic [3:0]  CRN_W1        = 4'd6;
    localparam logic [3:0]  CRN_LAST      = 4'd10;

    localparam logic [31:0] HP_INIT       = 32'h001f_001f;
    localparam int          HP_IRQ_FLAG   = 31;
    localparam int          HP_FIQ_FLAG   = 15;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic hp_init;
        logic scan_rd;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_hp;
        logic out_free;
    } t_sts;

endpackage

### design/sic_ctrl.sv
// ----------------------------------------------------------------------------
// sic_ctrl
// sequencer: capture, decode, priority slot scan, commit
// ----------------------------------------------------------------------------
module sic_ctrl #(
    parameter int PRIORITY_SLOTS = sic_pkg::PRIORITY_SLOTS_DEF,
    parameter int IDX_W          = $clog2(PRIORITY_SLOTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  sic_pkg::t_sts      i_sts,
    output sic_pkg::t_cmd      o_cmd,
    output logic [IDX_W-1:0]   o_scan_idx
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_hp) begin
                    o_cmd.hp_init = 1'b1;
                    n_idx         = '0;
                    n_state       = S_SCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (r_idx == IDX_W'(PRIORITY_SLOTS - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_scan_idx = r_idx;

endmodule

### design/sic_datapath.sv
// ----------------------------------------------------------------------------
// sic_datapath
// register file, priority slot memory, decode, scan accumulator, result register
// ----------------------------------------------------------------------------
module sic_datapath #(
    parameter int PRIORITY_SLOTS = sic_pkg::PRIORITY_SLOTS_DEF,
    parameter int IDX_W          = $clog2(PRIORITY_SLOTS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    input  logic [sic_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [sic_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [sic_pkg::M_TDATA_W-1:0] o_m_tdata,
    input  sic_pkg::t_cmd                 i_cmd,
    input  logic [IDX_W-1:0]              i_scan_idx,
    output sic_pkg::t_sts                 o_sts
);

    // captured item
    logic [2:0]  r_act;
    logic [13:0] r_off;
    logic [2:0]  r_size;
    logic [31:0] r_wd;
    logic [3:0]  r_crn;
    logic [2:0]  r_op1;
    logic [3:0]  r_crm;
    logic [2:0]  r_op2;
    logic        r_two;
    logic [3:0]  r_rx;
    logic [5:0]  r_src;
    logic        r_raise;

    // controller state
    logic [31:0] r_pend  [2];
    logic [31:0] r_mask  [2];
    logic [31:0] r_level [2];
    logic [31:0] n_pend  [2];
    logic [31:0] n_mask  [2];
    logic [31:0] n_level [2];
    logic        r_ctrl, n_ctrl;
    logic        r_gen2;

    // priority slots: {valid, source}
    logic [6:0]                r_slot_mem [PRIORITY_SLOTS];
    logic [PRIORITY_SLOTS-1:0] r_slot_wr;
    logic [IDX_W-1:0]          rd_addr;
    logic [6:0]                r_rd_raw;
    logic                      r_rd_written;
    logic                      r_rd_live;
    logic [31:0]               r_hp;

    // decode
    logic             d_ok, d_wr_word, d_rd_word, d_wr_ctrl, d_rd_ctrl;
    logic             d_wr_slot, d_rd_slot, d_hp, d_event, d_dest;
    logic [2:0]       d_kind;
    logic             d_word;
    logic [IDX_W-1:0] d_slot;

    logic        slot_valid;
    logic [5:0]  slot_src;
    logic [31:0] scan_irq_w, scan_fiq_w;
    logic [31:0] rd_word_val, rd_data;
    logic        n_irq, n_fiq;

    logic                          r_m_valid;
    logic [sic_pkg::M_TDATA_W-1:0] r_m_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act   <= i_s_tuser;
            r_off   <= i_s_tdata[sic_pkg::F_OFF_LSB  +: sic_pkg::F_OFF_W];
            r_size  <= i_s_tdata[sic_pkg::F_SIZE_LSB +: sic_pkg::F_SIZE_W];
            r_wd    <= i_s_tdata[sic_pkg::F_WD_LSB   +: sic_pkg::F_WD_W];
            r_crn   <= i_s_tdata[sic_pkg::F_CRN_LSB  +: sic_pkg::F_CRN_W];
            r_op1   <= i_s_tdata[sic_pkg::F_OP1_LSB  +: sic_pkg::F_OP1_W];
            r_crm   <= i_s_tdata[sic_pkg::F_CRM_LSB  +: sic_pkg::F_CRM_W];
            r_op2   <= i_s_tdata[sic_pkg::F_OP2_LSB  +: sic_pkg::F_OP2_W];
            r_two   <= i_s_tdata[sic_pkg::F_TWO_BIT];
            r_rx    <= i_s_tdata[sic_pkg::F_RX_LSB   +: sic_pkg::F_RX_W];
            r_src   <= i_s_tdata[sic_pkg::F_SRC_LSB  +: sic_pkg::F_SRC_W];
            r_raise <= i_s_tdata[sic_pkg::F_RAISE_BIT];
        end
    end

    // register decode of the captured item
    always_comb begin
        logic [5:0]  slot_num;
        logic [13:0] w1_rel;
        logic        is_wr;
        slot_num  = '0;
        w1_rel    = r_off - sic_pkg::OFF_W1_LO;
        is_wr     = 1'b0;
        d_ok      = 1'b0;
        d_wr_word = 1'b0;
        d_rd_word = 1'b0;
        d_wr_ctrl = 1'b0;
        d_rd_ctrl = 1'b0;
        d_wr_slot = 1'b0;
        d_rd_slot = 1'b0;
        d_hp      = 1'b0;
        d_event   = 1'b0;
        d_dest    = 1'b0;
        d_kind    = sic_pkg::KIND_IRQP;
        d_word    = 1'b0;
        d_slot    = '0;
        case (r_act)
            sic_pkg::ACT_BUS_RD, sic_pkg::ACT_BUS_WR: begin
                is_wr = (r_act == sic_pkg::ACT_BUS_WR);
                if (r_size == sic_pkg::SIZE_WORD) begin
                    if (r_off <= sic_pkg::OFF_W0_LAST) begin
                        d_ok      = 1'b1;
                        d_kind    = r_off[2:0];
                        d_wr_word = is_wr;
                        d_rd_word = !is_wr;
                    end else if (r_off >= sic_pkg::OFF_W1_LO
                                 && r_off <= sic_pkg::OFF_W1_HI) begin
                        d_ok      = r_gen2;
                        d_word    = 1'b1;
                        d_kind    = w1_rel[2:0];
                        d_wr_word = is_wr && r_gen2;
                        d_rd_word = !is_wr && r_gen2;
                    end else if (r_off == sic_pkg::OFF_CTRL) begin
                        d_ok      = 1'b1;
                        d_wr_ctrl = is_wr;
                        d_rd_ctrl = !is_wr;
                    end else if (r_off == sic_pkg::OFF_HP) begin
                        d_ok = r_gen2;
                        d_hp = !is_wr && r_gen2;
                    end else if ((r_off >= sic_pkg::OFF_SLOTA_LO
                                  && r_off <= sic_pkg::OFF_SLOTA_HI)
                                 || (r_off >= sic_pkg::OFF_SLOTB_LO
                                  && r_off <= sic_pkg::OFF_SLOTB_HI)) begin
                        // offsets stay below 64 here
                        if (r_off <= sic_pkg::OFF_SLOTA_HI) begin
                            slot_num = r_off[5:0] - sic_pkg::OFF_SLOTA_LO[5:0];
                        end else begin
                            slot_num = r_off[5:0] - sic_pkg::SLOTB_BASE;
                        end
                        if (slot_num < PRIORITY_SLOTS) begin
                            d_ok      = 1'b1;
                            d_slot    = slot_num[IDX_W-1:0];
                            d_wr_slot = is_wr;
                            d_rd_slot = !is_wr;
                        end
                    end
                end
            end
            sic_pkg::ACT_COP_RD, sic_pkg::ACT_COP_WR: begin
                is_wr = (r_act == sic_pkg::ACT_COP_WR);
                if (r_gen2 && r_crm == '0 && r_op1 == '0 && r_op2 == '0 && !r_two) begin
                    if (r_crn == sic_pkg::CRN_HP) begin
                        d_ok   = !is_wr;
                        d_hp   = !is_wr;
                        d_dest = !is_wr;
                    end else if (r_crn <= sic_pkg::CRN_LAST) begin
                        d_word = (r_crn >= sic_pkg::CRN_W1);
                        d_kind = d_word ? 3'(r_crn - sic_pkg::CRN_W1) : r_crn[2:0];
                        if (is_wr) begin
                            // only mask and level are writable from the coprocessor
                            d_ok      = (d_kind == sic_pkg::KIND_MASK)
                                        || (d_kind == sic_pkg::KIND_LEVEL);
                            d_wr_word = d_ok;
                        end else begin
                            d_ok      = 1'b1;
                            d_rd_word = 1'b1;
                            d_dest    = 1'b1;
                        end
                    end
                end
            end
            sic_pkg::ACT_EVENT: begin
                d_ok    = 1'b1;
                d_event = 1'b1;
            end
            default: begin
                d_ok = 1'b0;
            end
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen2 <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_gen2 <= i_cfg_wr_data;
        end
    end

    // slot memory, one read port with registered data
    assign rd_addr = i_cmd.scan_rd ? i_scan_idx : d_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && d_wr_slot) begin
            r_slot_mem[d_slot] <= {r_wd[31], r_wd[5:0]};
        end
        r_rd_raw <= r_slot_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_wr    <= '0;
            r_rd_written <= 1'b0;
            r_rd_live    <= 1'b0;
        end else begin
            if (i_cmd.commit && d_wr_slot) begin
                r_slot_wr[d_slot] <= 1'b1;
            end
            r_rd_written <= r_slot_wr[rd_addr];
            r_rd_live    <= i_cmd.scan_rd;
        end
    end

    // never written slot reads as zero
    assign slot_valid = r_rd_written && r_rd_raw[6];
    assign slot_src   = r_rd_written ? r_rd_raw[5:0] : 6'd0;

    // highest priority accumulator, one slot a cycle
    assign scan_irq_w = r_pend[slot_src[5]] & r_mask[slot_src[5]] & ~r_level[slot_src[5]];
    assign scan_fiq_w = r_pend[slot_src[5]] & r_mask[slot_src[5]] & r_level[slot_src[5]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.hp_init) begin
            r_hp <= sic_pkg::HP_INIT;
        end else if (r_rd_live && slot_valid) begin
            if (!r_hp[sic_pkg::HP_IRQ_FLAG] && scan_irq_w[slot_src[4:0]]) begin
                r_hp[sic_pkg::HP_IRQ_FLAG] <= 1'b1;
                r_hp[21:16]                <= slot_src;
            end
            if (!r_hp[sic_pkg::HP_FIQ_FLAG] && scan_fiq_w[slot_src[4:0]]) begin
                r_hp[sic_pkg::HP_FIQ_FLAG] <= 1'b1;
                r_hp[5:0]                  <= slot_src;
            end
        end
    end

    // next register values at commit
    always_comb begin
        n_pend[0]  = r_pend[0];
        n_pend[1]  = r_pend[1];
        n_mask[0]  = r_mask[0];
        n_mask[1]  = r_mask[1];
        n_level[0] = r_level[0];
        n_level[1] = r_level[1];
        n_ctrl     = r_ctrl;
        if (i_cmd.commit) begin
            if (d_wr_word && d_kind == sic_pkg::KIND_MASK) begin
                n_mask[d_word] = r_wd;
            end
            if (d_wr_word && d_kind == sic_pkg::KIND_LEVEL) begin
                n_level[d_word] = r_wd;
            end
            if (d_wr_ctrl) begin
                n_ctrl = r_wd[0];
            end
            if (d_event) begin
                n_pend[r_src[5]][r_src[4:0]] = r_raise;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend[0]  <= '0;
            r_pend[1]  <= '0;
            r_mask[0]  <= '0;
            r_mask[1]  <= '0;
            r_level[0] <= '0;
            r_level[1] <= '0;
            r_ctrl     <= 1'b0;
        end else begin
            r_pend[0]  <= n_pend[0];
            r_pend[1]  <= n_pend[1];
            r_mask[0]  <= n_mask[0];
            r_mask[1]  <= n_mask[1];
            r_level[0] <= n_level[0];
            r_level[1] <= n_level[1];
            r_ctrl     <= n_ctrl;
        end
    end

    assign n_irq = |((n_pend[0] & n_mask[0] & ~n_level[0])
                   | (n_pend[1] & n_mask[1] & ~n_level[1]));
    assign n_fiq = |((n_pend[0] & n_mask[0] & n_level[0])
                   | (n_pend[1] & n_mask[1] & n_level[1]));

    // read data
    always_comb begin
        case (d_kind)
            sic_pkg::KIND_IRQP:  rd_word_val = r_pend[d_word] & r_mask[d_word] & ~r_level[d_word];
            sic_pkg::KIND_MASK:  rd_word_val = r_mask[d_word];
            sic_pkg::KIND_LEVEL: rd_word_val = r_level[d_word];
            sic_pkg::KIND_FIQP:  rd_word_val = r_pend[d_word] & r_mask[d_word] & r_level[d_word];
            default:             rd_word_val = r_pend[d_word];
        endcase
    end

    always_comb begin
        rd_data = '0;
        if (d_rd_word) begin
            rd_data = rd_word_val;
        end else if (d_rd_ctrl) begin
            rd_data = {31'd0, r_ctrl};
        end else if (d_rd_slot) begin
            rd_data = {slot_valid, 25'd0, slot_src};
        end else if (d_hp) begin
            rd_data = r_hp;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_m_data <= {1'b0, (d_dest ? r_rx : 4'd0), n_fiq, n_irq, d_ok, rd_data};
        end
    end

    assign o_m_tvalid     = r_m_valid;
    assign o_m_tdata      = r_m_data;
    assign o_sts.is_hp    = d_hp;
    assign o_sts.out_free = !r_m_valid || i_m_tready;

endmodule

### design/soc_interrupt_controller.sv
// ----------------------------------------------------------------------------
// soc_interrupt_controller
// 64-source interrupt controller with mask, level routing and priority slots
// ----------------------------------------------------------------------------
// register accesses and events: captured, decoded, then committed once the result slot is free
// highest-priority reads scan every slot, then drain, one slot read per cycle in the scan
// one item in flight: a new item is taken only in idle, after the previous commit; a new
//   item is taken while the previous result waits
// reset (i_rst_n low, synchronous) clears pending/mask/level, control bit and
//   slot valid flags at once; no clearing pass, second generation comes up on
module soc_interrupt_controller #(
    parameter int PRIORITY_SLOTS = sic_pkg::PRIORITY_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: second generation enable
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    // input items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // word_offset[13:0], access_size[16:14], write_data[48:17],
    // coproc_reg[52:49], coproc_opcode1[55:53], coproc_crm[59:56],
    // coproc_opcode2[62:60], coproc_second_form[63], cpu_register[67:64],
    // source_number[73:68], source_raise[74], zero[79:75]
    input  logic [sic_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // action[2:0]
    input  logic [sic_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // result items
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // read_data[31:0], access_ok[32], irq_line[33], fiq_line[34],
    // dest_register[38:35], zero[39]
    output logic [sic_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(PRIORITY_SLOTS);

    sic_pkg::t_cmd     cmd;
    sic_pkg::t_sts     sts;
    logic [IDX_W-1:0]  scan_idx;

    // sequencer: idle -> decode -> (slot scan) -> commit when result slot is free
    sic_ctrl #(
        .PRIORITY_SLOTS (PRIORITY_SLOTS),
        .IDX_W          (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_scan_idx (scan_idx)
    );

    // register file, slot memory and result register
    sic_datapath #(
        .PRIORITY_SLOTS (PRIORITY_SLOTS),
        .IDX_W          (IDX_W)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tdata     (m_axis_tdata),
        .i_cmd         (cmd),
        .i_scan_idx    (scan_idx),
        .o_sts         (sts)
    );

endmodule
